// ----- design/ttx_pkg.sv -----
`default_nettype none
package ttx_pkg;

  localparam int MAGAZINES = 8;
  localparam int SLOT_W = $clog2(MAGAZINES);

  localparam logic [5:0] POS_FRAMING    = 6'd1;
  localparam logic [5:0] POS_ADDR_LOW   = 6'd2;
  localparam logic [5:0] POS_ADDR_HIGH  = 6'd3;
  localparam logic [5:0] POS_FIRST_DATA = 6'd4;
  localparam logic [5:0] POS_HDR_LAST   = 6'd11;
  localparam logic [5:0] POS_LAST       = 6'd43;
  localparam logic [5:0] UNIT_BYTES     = 6'd44;

  localparam logic [7:0] FRAMING_CODE = 8'hE4;
  localparam logic [7:0] NULL_PAGE    = 8'hFF;
  localparam logic [6:0] BAD_CHAR     = 7'd63;
  localparam logic [4:0] LAST_ROW     = 5'd24;

  localparam logic [7:0] CODE_WORDS [16] = '{
    8'h15, 8'h02, 8'h49, 8'h5e, 8'h64, 8'h73, 8'h38, 8'h2f,
    8'hd0, 8'hc7, 8'h8c, 8'h9b, 8'ha1, 8'hb6, 8'hfd, 8'hea
  };

  typedef enum logic [1:0] {
    KIND_HEADER = 2'd0,
    KIND_CHAR   = 2'd1,
    KIND_STATUS = 2'd2
  } kind_t;

  typedef enum logic [2:0] {
    STATUS_OK          = 3'd0,
    STATUS_BAD_FRAMING = 3'd1,
    STATUS_ADDR_ERROR  = 3'd2,
    STATUS_HDR_ERROR   = 3'd3,
    STATUS_NO_PAGE     = 3'd4,
    STATUS_NONDISPLAY  = 3'd5,
    STATUS_NULL_PAGE   = 3'd6
  } status_t;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       start_of_unit;
  } item_t;

  typedef struct packed {
    logic        valid;
    logic [7:0]  page;
    logic [13:0] sub;
  } entry_t;

  typedef struct packed {
    logic              clear_all;
    logic              write;
    logic [SLOT_W-1:0] slot;
    entry_t            entry;
  } table_cmd_t;

  typedef struct packed {
    kind_t       result_kind;
    logic [3:0]  magazine;
    logic [4:0]  row;
    logic [5:0]  column;
    logic [6:0]  char_code;
    logic        parity_bad;
    logic [7:0]  page_id;
    logic [13:0] subcode;
    logic [7:0]  control_flags;
    logic [2:0]  char_set;
    logic        hamming_fixed;
    status_t     status_code;
  } result_t;

  typedef struct packed {
    logic       ok;
    logic       fixed;
    logic [3:0] nib;
  } ham_t;

  function automatic logic [7:0] flip8(logic [7:0] v);
    logic [7:0] f;
    for (int i = 0; i < 8; i++) begin
      f[i] = v[7-i];
    end
    return f;
  endfunction

  // hamming 8/4: code distance 4, so at most one word lies within one bit
  function automatic ham_t ham_decode(logic [7:0] v);
    ham_t h;
    logic [7:0] d;
    h = '0;
    for (int i = 0; i < 16; i++) begin
      d = v ^ CODE_WORDS[i];
      if (d == 8'd0) begin
        h.ok = 1'b1;
        h.nib = 4'(i);
      end else if ((d & (d - 8'd1)) == 8'd0) begin
        h.ok = 1'b1;
        h.fixed = 1'b1;
        h.nib = 4'(i);
      end
    end
    return h;
  endfunction

  function automatic logic [3:0] mag_out(logic [2:0] m);
    return (m == 3'd0) ? 4'd8 : {1'b0, m};
  endfunction

  function automatic logic [SLOT_W-1:0] mag_slot(logic [2:0] m);
    return SLOT_W'(mag_out(m) - 4'd1);
  endfunction

endpackage
`default_nettype wire

// ----- design/ttx_in_if.sv -----
`default_nettype none
interface ttx_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       start_of_unit;

  modport source (output valid, data_byte, start_of_unit, input ready);
  modport sink (input valid, data_byte, start_of_unit, output ready);
endinterface
`default_nettype wire

// ----- design/ttx_out_if.sv -----
`default_nettype none
interface ttx_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  result_kind;
  logic [3:0]  magazine;
  logic [4:0]  row;
  logic [5:0]  column;
  logic [6:0]  char_code;
  logic        parity_bad;
  logic [7:0]  page_id;
  logic [13:0] subcode;
  logic [7:0]  control_flags;
  logic [2:0]  char_set;
  logic        hamming_fixed;
  logic [2:0]  status_code;

  modport source (output valid, result_kind, magazine, row, column, char_code, parity_bad,
                  page_id, subcode, control_flags, char_set, hamming_fixed,
                  status_code, input ready);
  modport sink (input valid, result_kind, magazine, row, column, char_code, parity_bad,
                page_id, subcode, control_flags, char_set, hamming_fixed,
                status_code, output ready);
endinterface
`default_nettype wire

// ----- design/ttx_in_reg.sv -----
`default_nettype none
module ttx_in_reg (
  input  wire logic     clk,
  input  wire logic     rst,
  ttx_in_if.sink        in_unit,
  input  wire logic     take,
  output ttx_pkg::item_t item,
  output logic          item_valid
);

  assign in_unit.ready = !item_valid || take;

  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else if (in_unit.ready) begin
      item_valid <= in_unit.valid;
    end
    if (in_unit.valid && in_unit.ready) begin
      item.data_byte <= in_unit.data_byte;
      item.start_of_unit <= in_unit.start_of_unit;
    end
  end

endmodule
`default_nettype wire

// ----- design/ttx_page_table.sv -----
`default_nettype none
module ttx_page_table (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire ttx_pkg::table_cmd_t           cmd,
  input  wire logic [ttx_pkg::SLOT_W-1:0]    rd_slot,
  output ttx_pkg::entry_t                    rd_entry
);

  logic [ttx_pkg::MAGAZINES-1:0] valid;
  logic [7:0]  page [ttx_pkg::MAGAZINES];
  logic [13:0] sub [ttx_pkg::MAGAZINES];

  // an invalid slot reads as the cleared entry
  always_comb begin
    rd_entry = '0;
    if (valid[rd_slot]) begin
      rd_entry.valid = 1'b1;
      rd_entry.page = page[rd_slot];
      rd_entry.sub = sub[rd_slot];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
    end else begin
      if (cmd.clear_all) begin
        valid <= '0;
      end
      if (cmd.write) begin
        valid[cmd.slot] <= cmd.entry.valid;
      end
    end
    if (cmd.write) begin
      page[cmd.slot] <= cmd.entry.page;
      sub[cmd.slot] <= cmd.entry.sub;
    end
  end

endmodule
`default_nettype wire

// ----- design/ttx_decode.sv -----
`default_nettype none
module ttx_decode (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire ttx_pkg::item_t              item,
  input  wire logic                        item_valid,
  input  wire logic                        out_free,
  output logic                             take,
  output logic                             load,
  output ttx_pkg::result_t                 res,
  output ttx_pkg::table_cmd_t              cmd,
  output logic [ttx_pkg::SLOT_W-1:0]       rd_slot,
  input  wire ttx_pkg::entry_t             rd_entry
);

  logic [5:0]      pos, pos_next;
  logic            dropped, dropped_next;
  logic [3:0]      addr_lo, addr_lo_next;
  logic [2:0]      cur_mag, cur_mag_next;
  logic [4:0]      cur_pkt, cur_pkt_next;
  logic [31:0]     hdr, hdr_next;
  logic            corrected, corrected_next;
  ttx_pkg::entry_t row_entry, row_entry_next;

  logic [7:0]      r;
  ttx_pkg::ham_t   ham;
  logic [2:0]      hidx;
  logic [31:0]     hdr_upd;
  logic [4:0]      pkt_new;
  logic            corr_now;
  ttx_pkg::entry_t hdr_entry;
  logic [7:0]      ctl;
  logic [2:0]      nat;

  function automatic ttx_pkg::result_t status_res(logic [3:0] mag, logic [4:0] row,
                                                  ttx_pkg::status_t st);
    ttx_pkg::result_t s;
    s = '0;
    s.result_kind = ttx_pkg::KIND_STATUS;
    s.magazine = mag;
    s.row = row;
    s.status_code = st;
    return s;
  endfunction

  assign take = item_valid && out_free;
  assign rd_slot = (pos == ttx_pkg::POS_ADDR_HIGH) ? ttx_pkg::mag_slot(addr_lo[2:0])
                                                   : ttx_pkg::mag_slot(cur_mag);

  always_comb begin
    r = ttx_pkg::flip8(item.data_byte);
    ham = ttx_pkg::ham_decode(r);
    hidx = 3'(pos - ttx_pkg::POS_FIRST_DATA);
    hdr_upd = hdr | (32'(ham.nib) << {hidx, 2'b00});
    pkt_new = {ham.nib, addr_lo[3]};
    hdr_entry.valid = 1'b1;
    hdr_entry.page = hdr_upd[7:0];
    hdr_entry.sub = {hdr_upd[21:20], hdr_upd[19:16], 1'b0, hdr_upd[14:12], hdr_upd[11:8]};
    ctl = {hdr_upd[28], hdr_upd[27:24], hdr_upd[23:22], hdr_upd[15]};
    nat = hdr_upd[31:29];

    pos_next = pos;
    dropped_next = dropped;
    addr_lo_next = addr_lo;
    cur_mag_next = cur_mag;
    cur_pkt_next = cur_pkt;
    hdr_next = hdr;
    row_entry_next = row_entry;
    corr_now = corrected;
    res = '0;
    load = 1'b0;
    cmd = '0;

    if (take) begin
      if (item.start_of_unit) begin
        pos_next = ttx_pkg::POS_FRAMING;
        dropped_next = 1'b0;
        corr_now = 1'b0;
        hdr_next = '0;
      end else if (dropped || pos >= ttx_pkg::UNIT_BYTES) begin
        dropped_next = 1'b1;
      end else begin
        pos_next = pos + 6'd1;
        if (pos == ttx_pkg::POS_LAST) begin
          dropped_next = 1'b1;
        end
        if (pos == ttx_pkg::POS_FRAMING) begin
          if (item.data_byte != ttx_pkg::FRAMING_CODE) begin
            load = 1'b1;
            dropped_next = 1'b1;
            res = status_res(4'd0, 5'd0, ttx_pkg::STATUS_BAD_FRAMING);
          end
        end else if (pos == ttx_pkg::POS_ADDR_LOW) begin
          corr_now = corrected | ham.fixed;
          if (!ham.ok) begin
            load = 1'b1;
            dropped_next = 1'b1;
            res = status_res(4'd0, 5'd0, ttx_pkg::STATUS_ADDR_ERROR);
          end else begin
            addr_lo_next = ham.nib;
          end
        end else if (pos == ttx_pkg::POS_ADDR_HIGH) begin
          corr_now = corrected | ham.fixed;
          if (!ham.ok) begin
            load = 1'b1;
            dropped_next = 1'b1;
            res = status_res(4'd0, 5'd0, ttx_pkg::STATUS_ADDR_ERROR);
          end else begin
            cur_mag_next = addr_lo[2:0];
            cur_pkt_next = pkt_new;
            if (pkt_new == 5'd0) begin
              load = 1'b0;
            end else if (pkt_new <= ttx_pkg::LAST_ROW) begin
              row_entry_next = rd_entry;
              if (!rd_entry.valid) begin
                load = 1'b1;
                dropped_next = 1'b1;
                res = status_res(ttx_pkg::mag_out(addr_lo[2:0]), pkt_new,
                                 ttx_pkg::STATUS_NO_PAGE);
              end
            end else begin
              load = 1'b1;
              dropped_next = 1'b1;
              res = status_res(ttx_pkg::mag_out(addr_lo[2:0]), pkt_new,
                               ttx_pkg::STATUS_NONDISPLAY);
            end
          end
        end else if (cur_pkt == 5'd0 && pos <= ttx_pkg::POS_HDR_LAST) begin
          corr_now = corrected | ham.fixed;
          if (!ham.ok) begin
            load = 1'b1;
            dropped_next = 1'b1;
            res = status_res(ttx_pkg::mag_out(cur_mag), 5'd0, ttx_pkg::STATUS_HDR_ERROR);
          end else begin
            hdr_next = hdr_upd;
            if (pos == ttx_pkg::POS_HDR_LAST) begin
              load = 1'b1;
              cmd.clear_all = ctl[7];
              cmd.write = 1'b1;
              cmd.slot = ttx_pkg::mag_slot(cur_mag);
              res.magazine = ttx_pkg::mag_out(cur_mag);
              res.page_id = hdr_entry.page;
              res.subcode = hdr_entry.sub;
              res.control_flags = ctl;
              res.char_set = nat;
              if (hdr_entry.page == ttx_pkg::NULL_PAGE) begin
                cmd.entry = '0;
                dropped_next = 1'b1;
                res.result_kind = ttx_pkg::KIND_STATUS;
                res.status_code = ttx_pkg::STATUS_NULL_PAGE;
              end else begin
                cmd.entry = hdr_entry;
                row_entry_next = hdr_entry;
                res.result_kind = ttx_pkg::KIND_HEADER;
                res.status_code = ttx_pkg::STATUS_OK;
              end
            end
          end
        end else begin
          load = 1'b1;
          res.result_kind = ttx_pkg::KIND_CHAR;
          res.magazine = ttx_pkg::mag_out(cur_mag);
          res.row = cur_pkt;
          res.column = pos - ttx_pkg::POS_FIRST_DATA;
          res.parity_bad = ~(^r);
          res.char_code = res.parity_bad ? ttx_pkg::BAD_CHAR : r[6:0];
          res.page_id = row_entry.page;
          res.subcode = row_entry.sub;
        end
      end
    end
    res.hamming_fixed = corr_now;
    corrected_next = corr_now;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pos <= '0;
      dropped <= 1'b1;
      addr_lo <= '0;
      cur_mag <= '0;
      cur_pkt <= '0;
      hdr <= '0;
      corrected <= 1'b0;
      row_entry <= '0;
    end else begin
      pos <= pos_next;
      dropped <= dropped_next;
      addr_lo <= addr_lo_next;
      cur_mag <= cur_mag_next;
      cur_pkt <= cur_pkt_next;
      hdr <= hdr_next;
      corrected <= corrected_next;
      row_entry <= row_entry_next;
    end
  end

endmodule
`default_nettype wire

// ----- design/ttx_out_reg.sv -----
`default_nettype none
module ttx_out_reg (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             load,
  input  wire ttx_pkg::result_t res,
  output logic                  out_free,
  ttx_out_if.source             out_result
);

  ttx_pkg::result_t held;

  assign out_free = !out_result.valid || out_result.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_result.valid <= 1'b0;
    end else if (out_free) begin
      out_result.valid <= load;
    end
    if (load) begin
      held <= res;
    end
  end

  assign out_result.result_kind = held.result_kind;
  assign out_result.magazine = held.magazine;
  assign out_result.row = held.row;
  assign out_result.column = held.column;
  assign out_result.char_code = held.char_code;
  assign out_result.parity_bad = held.parity_bad;
  assign out_result.page_id = held.page_id;
  assign out_result.subcode = held.subcode;
  assign out_result.control_flags = held.control_flags;
  assign out_result.char_set = held.char_set;
  assign out_result.hamming_fixed = held.hamming_fixed;
  assign out_result.status_code = held.status_code;

endmodule
`default_nettype wire

// ----- design/teletext_data_unit_decoder_top.sv -----
// Teletext data unit decoder.
// in_unit takes the 44-byte DVB teletext data unit one byte per transaction,
// with start_of_unit set on the field/line byte. out_result gives at most one
// result per input byte: a page header, a display character or a status event.
// Each byte is registered at the input, decoded by one level of table compares
// and bit slicing, and the result is registered at the output: a result is
// valid on the cycle after the clock edge at which its byte's processing ran.
// One byte per cycle is taken sustained while the receiver holds ready high;
// a single decode stage lies between the input and output registers.
// Reset leaves no unit in progress and every magazine without an active page;
// bytes are ignored until a start byte arrives.
// When the receiver holds ready low the output register keeps its result, the
// input register fills, and in_unit.ready falls until the result is taken.
// The active page table is eight registered slots, cleared at reset at once.
`default_nettype none
module teletext_data_unit_decoder_top (
  input  wire logic clk,
  input  wire logic rst,
  ttx_in_if.sink    in_unit,
  ttx_out_if.source out_result
);

  ttx_pkg::item_t              item;
  logic                        item_valid;
  logic                        take;
  logic                        load;
  logic                        out_free;
  ttx_pkg::result_t            res;
  ttx_pkg::table_cmd_t         cmd;
  logic [ttx_pkg::SLOT_W-1:0]  rd_slot;
  ttx_pkg::entry_t             rd_entry;

  ttx_in_reg u_in_reg (
    .clk        (clk),
    .rst        (rst),
    .in_unit    (in_unit),
    .take       (take),
    .item       (item),
    .item_valid (item_valid)
  );

  ttx_decode u_decode (
    .clk        (clk),
    .rst        (rst),
    .item       (item),
    .item_valid (item_valid),
    .out_free   (out_free),
    .take       (take),
    .load       (load),
    .res        (res),
    .cmd        (cmd),
    .rd_slot    (rd_slot),
    .rd_entry   (rd_entry)
  );

  ttx_page_table u_page_table (
    .clk      (clk),
    .rst      (rst),
    .cmd      (cmd),
    .rd_slot  (rd_slot),
    .rd_entry (rd_entry)
  );

  ttx_out_reg u_out_reg (
    .clk        (clk),
    .rst        (rst),
    .load       (load),
    .res        (res),
    .out_free   (out_free),
    .out_result (out_result)
  );

endmodule
`default_nettype wire

// ----- design/ttx_check.sv -----
`default_nettype none
module ttx_check (
  input wire logic       clk,
  input wire logic       rst,
  input wire logic       out_valid,
  input wire logic       out_ready,
  input wire logic [1:0] result_kind,
  input wire logic [5:0] column,
  input wire logic [6:0] char_code,
  input wire logic       parity_bad,
  input wire logic [2:0] status_code
);

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(result_kind) && $stable(column))
    else $error("result changed while stalled");

  a_kind_known: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> result_kind == ttx_pkg::KIND_HEADER || result_kind == ttx_pkg::KIND_CHAR
                  || result_kind == ttx_pkg::KIND_STATUS)
    else $error("unknown result kind");

  a_char_fields: assert property (@(posedge clk) disable iff (rst)
    out_valid && result_kind == ttx_pkg::KIND_CHAR
      |-> status_code == ttx_pkg::STATUS_OK && column < 6'd40)
    else $error("bad character result fields");

  a_bad_parity_char: assert property (@(posedge clk) disable iff (rst)
    out_valid && result_kind == ttx_pkg::KIND_CHAR && parity_bad
      |-> char_code == ttx_pkg::BAD_CHAR)
    else $error("parity failure without substitute character");

  a_status_clean: assert property (@(posedge clk) disable iff (rst)
    out_valid && result_kind == ttx_pkg::KIND_STATUS
      |-> column == 6'd0 && char_code == 7'd0 && !parity_bad
          && status_code != ttx_pkg::STATUS_OK)
    else $error("bad status result fields");

endmodule

bind teletext_data_unit_decoder_top ttx_check u_ttx_check (
  .clk         (clk),
  .rst         (rst),
  .out_valid   (out_result.valid),
  .out_ready   (out_result.ready),
  .result_kind (out_result.result_kind),
  .column      (out_result.column),
  .char_code   (out_result.char_code),
  .parity_bad  (out_result.parity_bad),
  .status_code (out_result.status_code)
);
`default_nettype wire

// ----- verif/ttx_checker.sv -----
`default_nettype none
module ttx_checker (
  input  wire logic clk,
  input  wire logic rst,
  ttx_in_if         in_unit,
  ttx_out_if        out_result,
  output int        fail_count,
  output int        pending
);
  timeunit 1ns;
  timeprecision 1ps;
  import ttx_pkg::*;

  logic [5:0]  unit_pos;
  logic        unit_idle;
  logic [3:0]  addr_nib;
  logic [2:0]  cur_mag;
  logic [4:0]  cur_packet;
  logic [31:0] hdr_word;
  logic        repair_seen;
  entry_t      row_page;
  entry_t      page_table [MAGAZINES];
  result_t     expected_q [$];
  result_t     want;
  int          errors = 0;

  function automatic logic [7:0] bit_mirror(logic [7:0] v);
    logic [7:0] m;
    for (int i = 0; i < 8; i++) begin
      m[7-i] = v[i];
    end
    return m;
  endfunction

  // nearest code word; 16 when no word lies within one bit
  function automatic int hamming_nibble(logic [7:0] v);
    int best;
    int best_d;
    int d;
    best = 0;
    best_d = 9;
    for (int i = 0; i < 16; i++) begin
      d = $countones(v ^ CODE_WORDS[i]);
      if (d < best_d) begin
        best_d = d;
        best = i;
      end
    end
    if (best_d > 1) return 16;
    if (best_d == 1) repair_seen = 1'b1;
    return best;
  endfunction

  function automatic logic [3:0] mag_number();
    return (cur_mag == 3'd0) ? 4'd8 : {1'b0, cur_mag};
  endfunction

  task automatic push_result(kind_t kind, logic [3:0] mag, logic [4:0] row, logic [5:0] col,
                             logic [6:0] ch, logic pbad, entry_t e, logic [7:0] ctl,
                             logic [2:0] nat, status_t st);
    result_t r;
    r.result_kind     = kind;
    r.magazine        = mag;
    r.row             = row;
    r.column          = col;
    r.char_code       = ch;
    r.parity_bad      = pbad;
    r.page_id         = e.page;
    r.subcode         = e.sub;
    r.control_flags   = ctl;
    r.char_set        = nat;
    r.hamming_fixed   = repair_seen;
    r.status_code     = st;
    expected_q.push_back(r);
  endtask

  task automatic drop_unit(logic [3:0] mag, logic [4:0] row, status_t st);
    unit_idle = 1'b1;
    push_result(KIND_STATUS, mag, row, 6'd0, 7'd0, 1'b0, '0, 8'd0, 3'd0, st);
  endtask

  task automatic decode_byte(logic [7:0] b, logic s);
    logic [7:0] r;
    logic [5:0] p;
    int         nib;
    logic [3:0] units, tens, s1, s2c4, s3, s4c56, c7c10, c11c14;
    logic [7:0] ctl;
    logic [2:0] slot;
    logic       bad;
    entry_t     e;
    if (s) begin
      unit_pos = 6'd1;
      unit_idle = 1'b0;
      repair_seen = 1'b0;
      hdr_word = '0;
      return;
    end
    if (unit_idle || unit_pos >= UNIT_BYTES) begin
      unit_idle = 1'b1;
      return;
    end
    p = unit_pos;
    unit_pos = unit_pos + 6'd1;
    if (p == POS_LAST) unit_idle = 1'b1;
    if (p == POS_FRAMING) begin
      if (b != FRAMING_CODE) drop_unit(4'd0, 5'd0, STATUS_BAD_FRAMING);
      return;
    end
    r = bit_mirror(b);
    if (p == POS_ADDR_LOW) begin
      nib = hamming_nibble(r);
      if (nib > 15) drop_unit(4'd0, 5'd0, STATUS_ADDR_ERROR);
      else addr_nib = nib[3:0];
      return;
    end
    if (p == POS_ADDR_HIGH) begin
      nib = hamming_nibble(r);
      if (nib > 15) begin
        drop_unit(4'd0, 5'd0, STATUS_ADDR_ERROR);
        return;
      end
      cur_mag = addr_nib[2:0];
      cur_packet = {nib[3:0], addr_nib[3]};
      slot = cur_mag - 3'd1;
      if (cur_packet == 5'd0) return;
      if (cur_packet <= LAST_ROW) begin
        row_page = page_table[slot];
        if (!row_page.valid) drop_unit(mag_number(), cur_packet, STATUS_NO_PAGE);
      end else begin
        drop_unit(mag_number(), cur_packet, STATUS_NONDISPLAY);
      end
      return;
    end
    if (cur_packet == 5'd0 && p <= POS_HDR_LAST) begin
      nib = hamming_nibble(r);
      if (nib > 15) begin
        drop_unit(mag_number(), 5'd0, STATUS_HDR_ERROR);
        return;
      end
      hdr_word[(int'(p) - int'(POS_FIRST_DATA)) * 4 +: 4] = nib[3:0];
      if (p != POS_HDR_LAST) return;
      units  = hdr_word[3:0];
      tens   = hdr_word[7:4];
      s1     = hdr_word[11:8];
      s2c4   = hdr_word[15:12];
      s3     = hdr_word[19:16];
      s4c56  = hdr_word[23:20];
      c7c10  = hdr_word[27:24];
      c11c14 = hdr_word[31:28];
      ctl = {c11c14[0], c7c10, s4c56[3:2], s2c4[3]};
      e.valid = 1'b1;
      e.page = {tens, units};
      e.sub = {s4c56[1:0], s3, 1'b0, s2c4[2:0], s1};
      // serial mode: one page active across all magazines
      if (c11c14[0]) begin
        foreach (page_table[i]) page_table[i] = '0;
      end
      slot = cur_mag - 3'd1;
      if (e.page == NULL_PAGE) begin
        page_table[slot] = '0;
        unit_idle = 1'b1;
        push_result(KIND_STATUS, mag_number(), 5'd0, 6'd0, 7'd0, 1'b0, e, ctl, c11c14[3:1],
                    STATUS_NULL_PAGE);
      end else begin
        page_table[slot] = e;
        row_page = e;
        push_result(KIND_HEADER, mag_number(), 5'd0, 6'd0, 7'd0, 1'b0, e, ctl, c11c14[3:1],
                    STATUS_OK);
      end
      return;
    end
    bad = ~^r;
    push_result(KIND_CHAR, mag_number(), cur_packet, p - POS_FIRST_DATA,
                bad ? BAD_CHAR : r[6:0], bad, row_page, 8'd0, 3'd0, STATUS_OK);
  endtask

  task automatic note_failure(string msg);
    errors++;
    if (errors <= 10) $display("mismatch: %s", msg);
  endtask

  task automatic check_field(string field, logic [15:0] exp_val, logic [15:0] act_val);
    if (exp_val !== act_val)
      note_failure($sformatf("%s expected %0d actual %0d", field, exp_val, act_val));
  endtask

  always @(posedge clk) begin
    if (rst) begin
      unit_pos = '0;
      unit_idle = 1'b1;
      addr_nib = '0;
      cur_mag = '0;
      cur_packet = '0;
      hdr_word = '0;
      repair_seen = 1'b0;
      row_page = '0;
      foreach (page_table[i]) page_table[i] = '0;
      expected_q.delete();
    end else begin
      if (in_unit.valid && in_unit.ready)
        decode_byte(in_unit.data_byte, in_unit.start_of_unit);
      if (out_result.valid && out_result.ready) begin
        if (expected_q.size() == 0) begin
          note_failure($sformatf("unexpected transaction kind %0d magazine %0d row %0d",
                                 out_result.result_kind, out_result.magazine, out_result.row));
        end else begin
          want = expected_q.pop_front();
          check_field("result_kind", want.result_kind, out_result.result_kind);
          check_field("magazine", want.magazine, out_result.magazine);
          check_field("row", want.row, out_result.row);
          check_field("column", want.column, out_result.column);
          check_field("char_code", want.char_code, out_result.char_code);
          check_field("parity_bad", want.parity_bad, out_result.parity_bad);
          check_field("page_id", want.page_id, out_result.page_id);
          check_field("subcode", want.subcode, out_result.subcode);
          check_field("control_flags", want.control_flags, out_result.control_flags);
          check_field("char_set", want.char_set, out_result.char_set);
          check_field("hamming_fixed", want.hamming_fixed, out_result.hamming_fixed);
          check_field("status_code", want.status_code, out_result.status_code);
        end
      end
    end
    fail_count <= errors;
    pending <= expected_q.size();
  end

endmodule
`default_nettype wire

// ----- verif/tb.sv -----
`default_nettype none
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import ttx_pkg::*;

  localparam int RANDOM_ITEMS   = 1600;
  localparam int QUIET_TAIL     = 250;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int DRAIN_CYCLES   = 20;

  logic clk;
  logic rst;
  logic quiet = 1'b0;
  logic steady = 1'b0;
  int   sent = 0;
  int   idle_cycles = 0;
  int   fail_count;
  int   pending;

  ttx_in_if  in_unit ();
  ttx_out_if out_result ();

  teletext_data_unit_decoder_top i_dut (
    .clk        (clk),
    .rst        (rst),
    .in_unit    (in_unit),
    .out_result (out_result)
  );

  ttx_checker i_checker (
    .clk        (clk),
    .rst        (rst),
    .in_unit    (in_unit),
    .out_result (out_result),
    .fail_count (fail_count),
    .pending    (pending)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  function automatic logic [7:0] mirror_byte(logic [7:0] v);
    logic [7:0] m;
    for (int i = 0; i < 8; i++) begin
      m[7-i] = v[i];
    end
    return m;
  endfunction

  // code word for a nibble with some bits inverted, in line order
  function automatic logic [7:0] ham_byte(logic [3:0] nib, int flips);
    logic [7:0] mask;
    mask = '0;
    while ($countones(mask) < flips) mask[$urandom_range(0, 7)] = 1'b1;
    return mirror_byte(CODE_WORDS[nib] ^ mask);
  endfunction

  function automatic int flips();
    int roll;
    roll = $urandom_range(0, 199);
    return (roll < 8) ? 1 : (roll < 11) ? 2 : (roll < 12) ? 3 : 0;
  endfunction

  function automatic logic [7:0] char_byte(logic good);
    logic [6:0] c;
    c = 7'($urandom_range(0, 127));
    return mirror_byte({good ? ~^c : ^c, c});
  endfunction

  task automatic send_byte(logic [7:0] b, logic s);
    if (!quiet && !steady && $urandom_range(0, 4) == 0) begin
      in_unit.valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    in_unit.valid <= 1'b1;
    in_unit.data_byte <= b;
    in_unit.start_of_unit <= s;
    @(posedge clk);
    while (!in_unit.ready) @(posedge clk);
  endtask

  task automatic random_unit();
    logic [7:0] u [$];
    logic [3:0] nib [8];
    logic [2:0] mag;
    int         pkt;
    int         roll;
    int         keep;
    roll = $urandom_range(0, 99);
    mag = 3'($urandom_range(0, 7));
    if (roll < 40) pkt = 0;
    else if (roll < 92) pkt = $urandom_range(1, 24);
    else pkt = $urandom_range(25, 31);
    u.push_back(8'($urandom_range(0, 255)));
    u.push_back(($urandom_range(0, 39) == 0) ? 8'($urandom_range(0, 255)) : FRAMING_CODE);
    u.push_back(ham_byte({pkt[0], mag}, flips()));
    u.push_back(ham_byte(4'(pkt >> 1), flips()));
    if (pkt == 0) begin
      foreach (nib[i]) nib[i] = 4'($urandom_range(0, 15));
      if ($urandom_range(0, 5) == 0) begin
        nib[0] = 4'hF;
        nib[1] = 4'hF;
      end
      nib[7][0] = ($urandom_range(0, 5) == 0);
      foreach (nib[i]) u.push_back(ham_byte(nib[i], flips()));
    end
    while (u.size() < UNIT_BYTES) u.push_back(char_byte($urandom_range(0, 9) != 0));
    if ($urandom_range(0, 19) == 0) begin
      keep = $urandom_range(1, 43);
      while (u.size() > keep) void'(u.pop_back());
    end
    foreach (u[i]) begin
      send_byte(u[i], i == 0);
      sent++;
    end
    if ($urandom_range(0, 19) == 0) begin
      repeat ($urandom_range(1, 3)) send_byte(8'($urandom_range(0, 255)), 1'b0);
    end
  endtask

  initial begin
    int stall;
    stall = 0;
    out_result.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (quiet || steady) begin
        out_result.ready <= 1'b1;
      end else if (stall > 0) begin
        stall--;
        out_result.ready <= 1'b0;
      end else if ($urandom_range(0, 5) == 0) begin
        stall = $urandom_range(1, 4) - 1;
        out_result.ready <= 1'b0;
      end else begin
        out_result.ready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (in_unit.valid && in_unit.ready) || (out_result.valid && out_result.ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("Regression FAIL");
        $finish;
      end
    end
  end

  initial begin
    rst <= 1'b1;
    in_unit.valid <= 1'b0;
    in_unit.data_byte <= 8'd0;
    in_unit.start_of_unit <= 1'b0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // bytes with no unit in progress
    send_byte(8'h00, 1'b0);
    send_byte(8'hFF, 1'b0);
    // bad framing, then a stray byte
    send_byte(8'hFF, 1'b1);
    send_byte(8'h00, 1'b0);
    send_byte(FRAMING_CODE, 1'b0);
    // uncorrectable address
    send_byte(8'h00, 1'b1);
    send_byte(FRAMING_CODE, 1'b0);
    send_byte(ham_byte(4'h0, 2), 1'b0);
    // repeated start, row 1 of magazine 8 with no page, repaired address bit
    send_byte(8'h2C, 1'b1);
    send_byte(8'h2C, 1'b1);
    send_byte(FRAMING_CODE, 1'b0);
    send_byte(ham_byte(4'h8, 1), 1'b0);
    send_byte(ham_byte(4'h0, 0), 1'b0);
    // packet 31 of magazine 7
    send_byte(8'h55, 1'b1);
    send_byte(FRAMING_CODE, 1'b0);
    send_byte(ham_byte(4'hF, 0), 1'b0);
    send_byte(ham_byte(4'hF, 0), 1'b0);
    // short unit cut by the next start
    send_byte(8'h00, 1'b1);
    send_byte(FRAMING_CODE, 1'b0);
    send_byte(ham_byte(4'h1, 0), 1'b0);

    while (sent < RANDOM_ITEMS) begin
      if (sent >= RANDOM_ITEMS - QUIET_TAIL) quiet = 1'b1;
      steady = ($urandom_range(0, 4) == 0);
      random_unit();
    end
    in_unit.valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
`default_nettype wire
